// ===== rtl/core/dkjt_pkg.sv =====
`timescale 1ns / 1ps

package dkjt_pkg;

    localparam int KEY_W      = 64;
    localparam int EXT_W      = 17;
    localparam int TAG_W      = 16;
    localparam int TABLE_AW   = 16;
    localparam int TABLE_SIZE = 1 << TABLE_AW;
    localparam int COUNT_W    = 17;
    localparam int NUM_DIMS   = 3;
    localparam int DIM_W      = 2;
    localparam int DIFF_W     = KEY_W + 1;
    localparam int PROD_W     = TABLE_AW + EXT_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int ENTRY_W    = TAG_W + 1;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_MATCHED  = 3'd1,
        ST_OUTSIDE  = 3'd2,
        ST_NOMATCH  = 3'd3,
        ST_DUP      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        REG_DIM_COUNT   = 3'd0,
        REG_KEY0_MIN    = 3'd1,
        REG_KEY0_EXTENT = 3'd2,
        REG_KEY1_MIN    = 3'd3,
        REG_KEY1_EXTENT = 3'd4,
        REG_KEY2_MIN    = 3'd5,
        REG_KEY2_EXTENT = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SUB,
        S_FOLD,
        S_READ,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic [DIM_W-1:0] dim_count;
        logic [KEY_W-1:0] key0_min;
        logic [EXT_W-1:0] key0_extent;
        logic [KEY_W-1:0] key1_min;
        logic [EXT_W-1:0] key1_extent;
        logic [KEY_W-1:0] key2_min;
        logic [EXT_W-1:0] key2_extent;
    } t_cfg;

    typedef struct packed {
        logic             clr_step;
        logic             load_in;
        logic             sub_en;
        logic             fold_en;
        logic             rd_en;
        logic             commit;
        logic [DIM_W-1:0] dim;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic fold_fail;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/core/dkjt_cfg_regs.sv =====
`timescale 1ns / 1ps

module dkjt_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [5:0]                   paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready,
    output dkjt_pkg::t_cfg               o_cfg
);

    dkjt_pkg::t_cfg   r_cfg;
    dkjt_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = dkjt_pkg::t_reg_idx'(paddr[5:3]);
    assign w_wr   = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dim_count   <= dkjt_pkg::DIM_W'(1);
            r_cfg.key0_min    <= '0;
            r_cfg.key0_extent <= dkjt_pkg::EXT_W'(1);
            r_cfg.key1_min    <= '0;
            r_cfg.key1_extent <= dkjt_pkg::EXT_W'(1);
            r_cfg.key2_min    <= '0;
            r_cfg.key2_extent <= dkjt_pkg::EXT_W'(1);
        end else if (w_wr) begin
            unique case (w_idx)
                dkjt_pkg::REG_DIM_COUNT:   r_cfg.dim_count   <= pwdata[dkjt_pkg::DIM_W-1:0];
                dkjt_pkg::REG_KEY0_MIN:    r_cfg.key0_min    <= pwdata;
                dkjt_pkg::REG_KEY0_EXTENT: r_cfg.key0_extent <= pwdata[dkjt_pkg::EXT_W-1:0];
                dkjt_pkg::REG_KEY1_MIN:    r_cfg.key1_min    <= pwdata;
                dkjt_pkg::REG_KEY1_EXTENT: r_cfg.key1_extent <= pwdata[dkjt_pkg::EXT_W-1:0];
                dkjt_pkg::REG_KEY2_MIN:    r_cfg.key2_min    <= pwdata;
                dkjt_pkg::REG_KEY2_EXTENT: r_cfg.key2_extent <= pwdata[dkjt_pkg::EXT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            dkjt_pkg::REG_DIM_COUNT:   prdata = 64'(r_cfg.dim_count);
            dkjt_pkg::REG_KEY0_MIN:    prdata = r_cfg.key0_min;
            dkjt_pkg::REG_KEY0_EXTENT: prdata = 64'(r_cfg.key0_extent);
            dkjt_pkg::REG_KEY1_MIN:    prdata = r_cfg.key1_min;
            dkjt_pkg::REG_KEY1_EXTENT: prdata = 64'(r_cfg.key1_extent);
            dkjt_pkg::REG_KEY2_MIN:    prdata = r_cfg.key2_min;
            dkjt_pkg::REG_KEY2_EXTENT: prdata = 64'(r_cfg.key2_extent);
            default:                   prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/dkjt_ctrl.sv =====
`timescale 1ns / 1ps

module dkjt_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [dkjt_pkg::DIM_W-1:0]     i_dim_count,
    input  dkjt_pkg::t_dp_sts              i_sts,
    output dkjt_pkg::t_dp_cmd              o_cmd
);

    dkjt_pkg::t_state             r_state, n_state;
    logic [dkjt_pkg::DIM_W-1:0]   r_dim, n_dim;
    logic [dkjt_pkg::DIM_W-1:0]   w_last;

    // zero dims behaves as one; three is the maximum the field can hold
    assign w_last = (i_dim_count == '0) ? '0 : i_dim_count - dkjt_pkg::DIM_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dkjt_pkg::S_CLEAR;
            r_dim   <= '0;
        end else begin
            r_state <= n_state;
            r_dim   <= n_dim;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_dim      = r_dim;
        o_cmd      = '0;
        o_cmd.dim  = r_dim;
        o_s_tready = 1'b0;
        unique case (r_state)
            dkjt_pkg::S_CLEAR: begin
                o_cmd.clr_step = ~i_sts.clr_done;
                if (i_sts.clr_done) begin
                    n_state = dkjt_pkg::S_IDLE;
                end
            end
            dkjt_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_dim         = '0;
                    n_state       = dkjt_pkg::S_SUB;
                end
            end
            dkjt_pkg::S_SUB: begin
                o_cmd.sub_en = 1'b1;
                n_state      = dkjt_pkg::S_FOLD;
            end
            dkjt_pkg::S_FOLD: begin
                o_cmd.fold_en = 1'b1;
                if (i_sts.fold_fail) begin
                    n_state = dkjt_pkg::S_DECIDE;
                end else if (r_dim == w_last) begin
                    n_state = dkjt_pkg::S_READ;
                end else begin
                    n_dim   = r_dim + dkjt_pkg::DIM_W'(1);
                    n_state = dkjt_pkg::S_SUB;
                end
            end
            dkjt_pkg::S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = dkjt_pkg::S_DECIDE;
            end
            dkjt_pkg::S_DECIDE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = dkjt_pkg::S_IDLE;
                end
            end
            default: n_state = dkjt_pkg::S_CLEAR;
        endcase
    end

endmodule

// ===== rtl/core/dkjt_dpath.sv =====
`timescale 1ns / 1ps

module dkjt_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dkjt_pkg::t_cfg                     i_cfg,
    input  dkjt_pkg::t_dp_cmd                  i_cmd,
    output dkjt_pkg::t_dp_sts                  o_sts,
    input  logic                               i_op,
    input  logic [dkjt_pkg::KEY_W-1:0]         i_key0,
    input  logic [dkjt_pkg::KEY_W-1:0]         i_key1,
    input  logic [dkjt_pkg::KEY_W-1:0]         i_key2,
    input  logic [dkjt_pkg::TAG_W-1:0]         i_tag,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output dkjt_pkg::t_status                  o_status,
    output logic [dkjt_pkg::TABLE_AW-1:0]      o_slot,
    output logic [dkjt_pkg::TAG_W-1:0]         o_build_row,
    output logic [dkjt_pkg::TAG_W-1:0]         o_probe_row,
    output logic [dkjt_pkg::COUNT_W-1:0]       o_entry_count,
    output logic                               o_dup_seen
);

    // entry = {occupied, row tag}
    logic [dkjt_pkg::ENTRY_W-1:0] mem [dkjt_pkg::TABLE_SIZE];

    logic [dkjt_pkg::TABLE_AW:0]   r_clr_addr;
    logic                          r_op;
    logic [dkjt_pkg::KEY_W-1:0]    r_key [dkjt_pkg::NUM_DIMS];
    logic [dkjt_pkg::TAG_W-1:0]    r_tag;
    logic [dkjt_pkg::DIFF_W-1:0]   r_diff;
    logic [dkjt_pkg::TABLE_AW-1:0] r_pos;
    logic                          r_outside;
    logic [dkjt_pkg::ENTRY_W-1:0]  r_rd;
    logic [dkjt_pkg::COUNT_W-1:0]  r_count;
    logic                          r_dup;
    logic                          r_out_valid;
    dkjt_pkg::t_status             r_out_status;
    logic [dkjt_pkg::TABLE_AW-1:0] r_out_slot;
    logic [dkjt_pkg::TAG_W-1:0]    r_out_brow;
    logic [dkjt_pkg::TAG_W-1:0]    r_out_prow;

    logic [dkjt_pkg::KEY_W-1:0]    w_key, w_min;
    logic [dkjt_pkg::EXT_W-1:0]    w_ext;
    logic [dkjt_pkg::EXT_W-1:0]    w_off;
    logic                          w_range_bad;
    logic [dkjt_pkg::PROD_W-1:0]   w_prod;
    logic [dkjt_pkg::SUM_W-1:0]    w_sum;
    logic                          w_ovf;
    logic                          w_occ;
    logic                          w_ins;
    dkjt_pkg::t_status             w_status;
    logic [dkjt_pkg::TAG_W-1:0]    w_brow;
    logic                          w_we;
    logic [dkjt_pkg::TABLE_AW-1:0] w_waddr;
    logic [dkjt_pkg::ENTRY_W-1:0]  w_wdata;

    always_comb begin
        unique case (i_cmd.dim)
            2'd0: begin
                w_key = r_key[0];
                w_min = i_cfg.key0_min;
                w_ext = i_cfg.key0_extent;
            end
            2'd1: begin
                w_key = r_key[1];
                w_min = i_cfg.key1_min;
                w_ext = i_cfg.key1_extent;
            end
            default: begin
                w_key = r_key[2];
                w_min = i_cfg.key2_min;
                w_ext = i_cfg.key2_extent;
            end
        endcase
    end

    // range check on the registered signed difference, then mixed-radix step
    assign w_off       = r_diff[dkjt_pkg::EXT_W-1:0];
    assign w_range_bad = r_diff[dkjt_pkg::DIFF_W-1]
                       | (|r_diff[dkjt_pkg::KEY_W-1:dkjt_pkg::EXT_W])
                       | (w_off >= w_ext);
    assign w_prod      = dkjt_pkg::PROD_W'(r_pos) * dkjt_pkg::PROD_W'(w_ext);
    assign w_sum       = (i_cmd.dim == '0) ? dkjt_pkg::SUM_W'(w_off)
                                           : dkjt_pkg::SUM_W'(w_prod) + dkjt_pkg::SUM_W'(w_off);
    assign w_ovf       = |w_sum[dkjt_pkg::SUM_W-1:dkjt_pkg::TABLE_AW];

    assign o_sts.clr_done  = r_clr_addr[dkjt_pkg::TABLE_AW];
    assign o_sts.fold_fail = w_range_bad | w_ovf;
    assign o_sts.out_free  = ~r_out_valid | i_out_ready;

    assign w_occ = r_rd[dkjt_pkg::ENTRY_W-1];

    always_comb begin
        w_ins    = 1'b0;
        w_brow   = '0;
        w_status = dkjt_pkg::ST_OUTSIDE;
        if (!r_outside) begin
            if (!r_op) begin
                w_status = w_occ ? dkjt_pkg::ST_DUP : dkjt_pkg::ST_INSERTED;
                w_ins    = ~w_occ;
            end else if (w_occ) begin
                w_status = dkjt_pkg::ST_MATCHED;
                w_brow   = r_rd[dkjt_pkg::TAG_W-1:0];
            end else begin
                w_status = dkjt_pkg::ST_NOMATCH;
            end
        end
    end

    assign w_we    = i_cmd.clr_step | (i_cmd.commit & w_ins);
    assign w_waddr = i_cmd.clr_step ? r_clr_addr[dkjt_pkg::TABLE_AW-1:0] : r_pos;
    assign w_wdata = i_cmd.clr_step ? '0 : {1'b1, r_tag};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_dup       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + {{dkjt_pkg::TABLE_AW{1'b0}}, 1'b1};
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                if (w_ins && (r_count != '1)) begin
                    r_count <= r_count + dkjt_pkg::COUNT_W'(1);
                end
                if (w_status == dkjt_pkg::ST_DUP) begin
                    r_dup <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op      <= i_op;
            r_key[0]  <= i_key0;
            r_key[1]  <= i_key1;
            r_key[2]  <= i_key2;
            r_tag     <= i_tag;
            r_outside <= 1'b0;
        end
        if (i_cmd.sub_en) begin
            r_diff <= {w_key[dkjt_pkg::KEY_W-1], w_key} - {w_min[dkjt_pkg::KEY_W-1], w_min};
        end
        if (i_cmd.fold_en) begin
            r_pos <= w_sum[dkjt_pkg::TABLE_AW-1:0];
            if (w_range_bad || w_ovf) begin
                r_outside <= 1'b1;
            end
        end
        if (i_cmd.commit) begin
            r_out_status <= w_status;
            r_out_slot   <= r_outside ? '0 : r_pos;
            r_out_brow   <= w_brow;
            r_out_prow   <= r_tag;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot        = r_out_slot;
    assign o_build_row   = r_out_brow;
    assign o_probe_row   = r_out_prow;
    assign o_entry_count = r_count;
    assign o_dup_seen    = r_dup;

endmodule

// ===== rtl/core/dense_key_join_table_unit.sv =====
`timescale 1ns / 1ps
// Per item: one subtract and one fold step per dimension in use (1..3), on a shared
//   subtract/fold unit, then one table read and one commit; outside-domain items leave
//   the fold early. A new item is taken only after the last one has committed; the
//   result register frees the input side while it waits.
// Reset: synchronous, active low. A clearing pass then empties all 65536 table entries;
//   input is held off meanwhile, configuration writes are taken at any time.

module dense_key_join_table_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input item stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [207:0]  s_axis_tdata,   // key0[63:0], key1[127:64], key2[191:128], row_tag[207:192]
    input  logic          s_axis_tuser,   // opcode: 0 build, 1 probe
    // result stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [71:0]   m_axis_tdata,   // slot[15:0], build_row[31:16], probe_row[47:32],
                                          // entry_count[64:48], duplicate_seen[65], zero[71:66]
    output logic [2:0]    m_axis_tuser,   // status
    // configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);

    dkjt_pkg::t_cfg                       w_cfg;
    dkjt_pkg::t_dp_cmd                    w_cmd;
    dkjt_pkg::t_dp_sts                    w_sts;
    dkjt_pkg::t_status                    w_status;
    logic [dkjt_pkg::TABLE_AW-1:0]        w_slot;
    logic [dkjt_pkg::TAG_W-1:0]           w_brow;
    logic [dkjt_pkg::TAG_W-1:0]           w_prow;
    logic [dkjt_pkg::COUNT_W-1:0]         w_count;
    logic                                 w_dup;

    // register file: 64-bit registers at 8-byte spacing
    dkjt_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer: clear pass, then per item: subtract/fold per dim, read unless outside, commit
    dkjt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_dim_count (w_cfg.dim_count),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // key arithmetic, table memory, counters and result register
    dkjt_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_op          (s_axis_tuser),
        .i_key0        (s_axis_tdata[63:0]),
        .i_key1        (s_axis_tdata[127:64]),
        .i_key2        (s_axis_tdata[191:128]),
        .i_tag         (s_axis_tdata[207:192]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (w_status),
        .o_slot        (w_slot),
        .o_build_row   (w_brow),
        .o_probe_row   (w_prow),
        .o_entry_count (w_count),
        .o_dup_seen    (w_dup)
    );

    assign m_axis_tuser = w_status;
    assign m_axis_tdata = {6'd0, w_dup, w_count, w_prow, w_brow, w_slot};

    // no input transaction while the table is still being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_sts.clr_done |-> !s_axis_tready)
        else $error("input accepted during clearing pass");

    // a commit never overwrites a result that has not been taken
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> w_sts.out_free)
        else $error("result register overwritten");

    // an outside-domain result carries zero slot and zero build row
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_status == dkjt_pkg::ST_OUTSIDE)) |-> ((w_slot == '0) && (w_brow == '0)))
        else $error("outside-domain result carries data");

    // a duplicate result always shows the sticky flag set
    a_dup_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_status == dkjt_pkg::ST_DUP)) |-> w_dup)
        else $error("duplicate reported without sticky flag");

endmodule
